@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pointer-encoding decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define EHPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ehpd assertion failed");

// Checked at every edge, reset included.
`define EHPD_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ehpd reset assertion failed");

`endif

@@ src/ehpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ehpd_pkg
// Types and codes for the exception-handling pointer-encoding decoder.
// ----------------------------------------------------------------------------
package ehpd_pkg;

  localparam int unsigned PointerBytes = 8;
  localparam int unsigned InDataW      = 144;
  localparam int unsigned OutDataW     = 72;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LEB_LONG = 3'd1,
    ST_BAD_FMT  = 3'd2,
    ST_BAD_BASE = 3'd3,
    ST_INDIRECT = 3'd4
  } status_e;

  // Low nibble of the encoding byte
  localparam logic [3:0] FMT_ABS  = 4'h0;
  localparam logic [3:0] FMT_ULEB = 4'h1;
  localparam logic [3:0] FMT_U2   = 4'h2;
  localparam logic [3:0] FMT_U4   = 4'h3;
  localparam logic [3:0] FMT_U8   = 4'h4;
  localparam logic [3:0] FMT_SLEB = 4'h9;
  localparam logic [3:0] FMT_S2   = 4'ha;
  localparam logic [3:0] FMT_S4   = 4'hb;
  localparam logic [3:0] FMT_S8   = 4'hc;

  // Bits 6:4 of the encoding byte
  localparam logic [2:0] BASE_ABS    = 3'd0;
  localparam logic [2:0] BASE_PCREL  = 3'd1;
  localparam logic [2:0] BASE_REGION = 3'd2;

  typedef struct packed {
    logic        first;
    logic [7:0]  data_byte;
    logic [7:0]  encoding;
    logic [63:0] field_address;
    logic [63:0] region_base;
  } ehpd_req_t;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
    logic [3:0]  byte_count;
  } ehpd_res_t;

endpackage

@@ src/ehpd_core.sv @@
// ----------------------------------------------------------------------------
// ehpd_core
// Per-byte decode step: accumulator, shift and field state, base addition.
// ----------------------------------------------------------------------------
module ehpd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ehpd_pkg::ehpd_req_t req_i,
  output logic                res_vld_o,
  output ehpd_pkg::ehpd_res_t res_o
);
  import ehpd_pkg::*;

  logic        busy_q, busy_d;
  logic [63:0] acc_q;
  logic [6:0]  shift_q;
  logic [3:0]  taken_q;
  logic [7:0]  enc_q;
  logic [63:0] fa_q, rb_q;

  logic        live, fin, leb_long, bad_fmt, bad_base;
  logic [7:0]  enc, bpart;
  logic [3:0]  fmt, bt0, bt1, need;
  logic [6:0]  sh0, sh1;
  logic [63:0] fa, rb, acc0, acc_or, acc1, contrib, raw, sum;

  always_comb begin
    live  = req_i.first | busy_q;
    enc   = req_i.first ? req_i.encoding      : enc_q;
    fa    = req_i.first ? req_i.field_address : fa_q;
    rb    = req_i.first ? req_i.region_base   : rb_q;
    acc0  = req_i.first ? '0                  : acc_q;
    sh0   = req_i.first ? '0                  : shift_q;
    bt0   = req_i.first ? '0                  : taken_q;
    bt1   = (bt0 != 4'hf) ? bt0 + 4'd1 : bt0;
    fmt   = enc[3:0];

    // LEB bytes carry 7 payload bits
    bpart   = (fmt == FMT_ULEB || fmt == FMT_SLEB) ? {1'b0, req_i.data_byte[6:0]}
                                                     : req_i.data_byte;
    contrib = sh0[6] ? '0 : ({56'b0, bpart} << sh0[5:0]);
    acc_or  = acc0 | contrib;

    acc1     = acc0;
    sh1      = sh0;
    fin      = 1'b0;
    leb_long = 1'b0;
    bad_fmt  = 1'b0;
    need     = '0;

    case (fmt)
      FMT_ULEB: begin
        acc1 = acc_or;
        if (!req_i.data_byte[7]) begin
          fin = 1'b1;
        end else begin
          sh1      = sh0 + 7'd7;
          leb_long = sh1[6];
        end
      end
      FMT_SLEB: begin
        acc1 = acc_or;
        sh1  = sh0 + 7'd7;
        if (req_i.data_byte[7]) begin
          leb_long = sh1[6];
        end else begin
          if (!sh1[6] && req_i.data_byte[6]) begin
            acc1 = acc_or | ({64{1'b1}} << sh1[5:0]);
          end
          fin = 1'b1;
        end
      end
      FMT_ABS, FMT_U2, FMT_U4, FMT_U8, FMT_S2, FMT_S4, FMT_S8: begin
        acc1 = acc_or;
        sh1  = sh0 + 7'd8;
        case (fmt)
          FMT_ABS:        need = 4'(PointerBytes);
          FMT_U2, FMT_S2: need = 4'd2;
          FMT_U4, FMT_S4: need = 4'd4;
          default:        need = 4'd8;
        endcase
        fin = (bt1 >= need);
      end
      default: bad_fmt = 1'b1;
    endcase

    case (fmt)
      FMT_S2:  raw = {{48{acc1[15]}}, acc1[15:0]};
      FMT_S4:  raw = {{32{acc1[31]}}, acc1[31:0]};
      default: raw = acc1;
    endcase

    bad_base = 1'b0;
    case (enc[6:4])
      BASE_ABS:    sum = raw;
      BASE_PCREL:  sum = raw + fa;
      BASE_REGION: sum = raw + rb;
      default: begin
        sum      = '0;
        bad_base = 1'b1;
      end
    endcase

    res_o.byte_count = bt1;
    if (bad_fmt) begin
      res_o.value  = '0;
      res_o.status = ST_BAD_FMT;
    end else if (leb_long) begin
      res_o.value  = '0;
      res_o.status = ST_LEB_LONG;
    end else if (bad_base) begin
      res_o.value  = '0;
      res_o.status = ST_BAD_BASE;
    end else if (enc[7]) begin
      res_o.value  = sum;
      res_o.status = ST_INDIRECT;
    end else begin
      res_o.value  = sum;
      res_o.status = ST_OK;
    end

    res_vld_o = step_i & live & (fin | leb_long | bad_fmt);
    busy_d    = (step_i & live) ? !(fin | leb_long | bad_fmt) : busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Field state only matters while busy, so it carries no reset.
  always_ff @(posedge clk_i) begin
    if (step_i && live) begin
      acc_q   <= acc1;
      shift_q <= sh1;
      taken_q <= bt1;
      enc_q   <= enc;
      fa_q    <= fa;
      rb_q    <= rb;
    end
  end

endmodule

@@ src/eh_pointer_encoding_decoder.sv @@
// ----------------------------------------------------------------------------
// eh_pointer_encoding_decoder
// Streaming decoder for exception-handling table pointer encodings.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte of an encoded field per request. tuser marks the
//   first byte of a field; on that byte the encoding, the field address and
//   the region base in tdata are latched for the rest of the field.
//   Master channel: one request per completed field with the value after base
//   addition, a status code and the number of bytes consumed.
// Timing:
//   One byte is taken every cycle unless the output stalls. A byte goes to an input register, then
//   through one decode step (shift/OR into the accumulator and a 64-bit base
//   add) into the output register, from which the result of a field's last byte
//   is offered. Throughput is one byte per cycle while the output does not stall,
//   set by the single accumulator update per byte.
// Reset:
//   Both stages empty and the decoder idle; bytes not marked first are
//   dropped until a first byte arrives.
// Stall:
//   While the output request waits, the input register holds and s_axis_tready
//   falls once it is full; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eh_pointer_encoding_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte[7:0], encoding[15:8], field_address[79:16], region_base[143:80]
  input  logic [ehpd_pkg::InDataW-1:0]  s_axis_tdata,
  // first[0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // value[63:0], status[66:64], byte_count[70:67], zero pad[71]
  output logic [ehpd_pkg::OutDataW-1:0] m_axis_tdata
);
  import ehpd_pkg::*;

  logic      in_vld_q, in_vld_d;
  ehpd_req_t in_req_q, in_req_d;
  logic      out_vld_q, out_vld_d;
  ehpd_res_t out_res_q;

  logic      out_free, accept, step, res_vld;
  ehpd_res_t res;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = in_vld_q && out_free;

  always_comb begin
    in_req_d.first         = s_axis_tuser[0];
    in_req_d.data_byte     = s_axis_tdata[7:0];
    in_req_d.encoding      = s_axis_tdata[15:8];
    in_req_d.field_address = s_axis_tdata[79:16];
    in_req_d.region_base   = s_axis_tdata[143:80];

    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end

    out_vld_d = out_free ? (step && res_vld) : out_vld_q;
  end

  ehpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .req_i     (in_req_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_d;
    end
    if (out_free) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_res_q.byte_count, out_res_q.status, out_res_q.value};

  `EHPD_ASSERT(a_badfmt_one_byte,
    out_vld_q && out_res_q.status == ST_BAD_FMT |-> out_res_q.byte_count == 4'd1)
  `EHPD_ASSERT(a_leb_long_ten_bytes,
    out_vld_q && out_res_q.status == ST_LEB_LONG |-> out_res_q.byte_count == 4'd10)
  `EHPD_ASSERT(a_error_value_zero,
    out_vld_q && (out_res_q.status == ST_LEB_LONG || out_res_q.status == ST_BAD_FMT ||
                  out_res_q.status == ST_BAD_BASE) |-> out_res_q.value == '0)
  `EHPD_ASSERT(a_in_stage_holds,
    in_vld_q && !out_free |=> in_vld_q && $stable(in_req_q))
  `EHPD_ASSERT_RST(a_reset_empty,
    !rst_ni |=> !in_vld_q && !out_vld_q)

endmodule
